FILE: hw/rtl/agr_pkg.sv
// ----------------------------------------------------------------------------
// agr_pkg
// shared widths and constants for the adaptive grid rebinning block
// ----------------------------------------------------------------------------
package agr_pkg;
  localparam int MaxBinsDefault = 32;
  localparam int WeightW = 32;
  localparam int EdgeW = 17;
  localparam int IdxW = 6;
  localparam logic [EdgeW-1:0] EdgeOne = 17'h10000;
  localparam logic [IdxW-1:0] BinCountReset = 6'd20;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_t;

  typedef struct packed {
    logic             start;
    logic [EdgeW-1:0] diff;
    logic [WeightW-1:0] rem;
    logic [WeightW-1:0] w;
  } div_req_t;
endpackage

FILE: hw/rtl/agr_if.sv
// ----------------------------------------------------------------------------
// agr_in_if / agr_out_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface agr_in_if;
  import agr_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [IdxW-1:0]    bin_index;
  logic [WeightW-1:0] weight;
  logic [EdgeW-1:0]   edge_req;
  logic [WeightW-1:0] step;
  modport source (output valid, op, bin_index, weight, edge_req, step, input ready);
  modport sink (input valid, op, bin_index, weight, edge_req, step, output ready);
endinterface

interface agr_out_if;
  import agr_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  edge_index;
  logic [EdgeW-1:0] new_edge;
  logic             overrun;
  logic             last;
  modport source (output valid, edge_index, new_edge, overrun, last, input ready);
  modport sink (input valid, edge_index, new_edge, overrun, last, output ready);
endinterface

FILE: hw/rtl/agr_ram.sv
// ----------------------------------------------------------------------------
// agr_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module agr_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/agr_div.sv
// ----------------------------------------------------------------------------
// agr_div
// bit-serial quotient of diff * rem / w, one quotient bit a cycle
// ----------------------------------------------------------------------------
module agr_div import agr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [EdgeW-1:0] quot
);
  localparam int NumW = EdgeW + WeightW;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0]    num;
  logic [WeightW:0]   part;
  logic [WeightW-1:0] den;
  logic [NumW-1:0]    q;
  logic [CntW-1:0]    cnt;
  logic               busy;
  logic [WeightW:0]   trial;
  logic [WeightW:0]   diffw;

  assign trial = {part[WeightW-1:0], num[NumW-1]};
  assign diffw = trial - {1'b0, den};
  assign quot = q[EdgeW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num <= NumW'(req.diff) * NumW'(req.rem);
        den <= req.w;
        part <= '0;
        q <= '0;
        cnt <= CntW'(NumW);
        busy <= 1'b1;
      end else if (busy) begin
        num <= {num[NumW-2:0], 1'b0};
        if (!diffw[WeightW]) begin
          part <= diffw;
          q <= {q[NumW-2:0], 1'b1};
        end else begin
          part <= trial;
          q <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/adaptive_grid_rebin.sv
// ----------------------------------------------------------------------------
// adaptive_grid_rebin
// grid edge refinement: equal-weight rebinning over stored bin weights
//
// in: request channel; op load writes one bin weight and old upper edge
// (one request a cycle while idle), op run starts a walk over the cumulative weights
// with the given step. out: one result per new edge, edge_index 1..n,
// last on edge n, which is always 1.0. the new edges replace the old ones.
// a run sends each interior edge through the serial divider unless it
// needs no division, and each old bin stepped over costs a ram read;
// then the new edges are copied back bin by bin. no request is taken
// during a run. reset clears control state and sets bin_count to 20; ram
// contents stay undefined until loaded. a stalled receiver holds the walk
// at the output register.
// ----------------------------------------------------------------------------
module adaptive_grid_rebin import agr_pkg::*; #(
  parameter int MaxBins = MaxBinsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_wdata,
  agr_in_if.sink          in_ch,
  agr_out_if.source       out_ch
);
  localparam int AW = $clog2(MaxBins);

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_CHECK, S_RD, S_RDW, S_ADV, S_PLACE, S_DIV, S_EMIT, S_COPY, S_COPYW
  } state_t;

  state_t state;
  logic [IdxW-1:0]    bin_count;
  logic [IdxW:0]      nd;
  logic [IdxW:0]      i;
  logic [IdxW:0]      k;
  logic [WeightW-1:0] rc;
  logic [WeightW+IdxW:0] dr;
  logic [EdgeW-1:0]   lo, hi, edge_r;
  logic [WeightW-1:0] wk;
  logic               over;
  logic               hi_ge;
  div_req_t           dreq;
  logic               ddone;
  logic [EdgeW-1:0]   dquot;

  logic               w_we, e_we, n_we;
  logic [AW-1:0]      w_wa, e_wa, n_wa, w_ra, e_ra, n_ra;
  logic [WeightW-1:0] w_wd, w_rd;
  logic [EdgeW-1:0]   e_wd, e_rd, n_wd, n_rd;

  agr_ram #(.Width(WeightW), .Depth(MaxBins)) u_wram (
    .clk, .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
  agr_ram #(.Width(EdgeW), .Depth(MaxBins)) u_eram (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  agr_ram #(.Width(EdgeW), .Depth(MaxBins)) u_nram (
    .clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

  agr_div u_div (.clk, .rst, .req(dreq), .done(ddone), .quot(dquot));

  logic load_ok;
  logic [IdxW:0] bc_lim;
  assign load_ok = in_ch.valid && in_ch.ready && (in_ch.op == OP_LOAD)
                   && (in_ch.bin_index != '0) && ({1'b0, in_ch.bin_index} <= (IdxW+1)'(MaxBins));
  assign bc_lim = (bin_count < IdxW'(2)) ? (IdxW+1)'(2)
                : (({1'b0, bin_count} > (IdxW+1)'(MaxBins)) ? (IdxW+1)'(MaxBins)
                : {1'b0, bin_count});

  assign in_ch.ready = (state == S_IDLE);
  assign w_we = load_ok;
  assign w_wa = AW'(in_ch.bin_index - 1'b1);
  assign w_wd = in_ch.weight;
  assign w_ra = AW'(k - 1'b1);
  assign e_ra = (state == S_COPY) ? AW'(i) : AW'(k - 1'b1);
  assign n_ra = AW'(i);
  assign n_we = (state == S_EMIT) && out_ch.ready;
  assign n_wa = AW'(i - 1'b1);
  assign n_wd = out_ch.new_edge;
  assign e_we = load_ok || (state == S_COPYW);
  assign e_wa = load_ok ? AW'(in_ch.bin_index - 1'b1) : AW'(i);
  assign e_wd = load_ok ? in_ch.edge_req : n_rd;
  assign hi_ge = (hi >= lo);

  always_comb begin
    dreq.start = (state == S_PLACE) && (k != '0) && (wk != '0);
    dreq.diff = hi_ge ? (hi - lo) : (lo - hi);
    dreq.rem = (dr > (WeightW+IdxW+1)'(wk)) ? wk : dr[WeightW-1:0];
    dreq.w = wk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bin_count <= BinCountReset;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        bin_count <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.op == OP_RUN) begin
            nd <= bc_lim;
            rc <= in_ch.step;
            dr <= '0;
            k <= '0;
            lo <= '0;
            hi <= '0;
            over <= 1'b0;
            i <= (IdxW+1)'(1);
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (i >= nd) begin
            out_ch.edge_index <= IdxW'(nd);
            out_ch.new_edge <= EdgeOne;
            out_ch.overrun <= over;
            out_ch.last <= 1'b1;
            out_ch.valid <= 1'b1;
            state <= S_EMIT;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((WeightW+IdxW+1)'(rc) > dr) begin
            if (k >= nd) begin
              over <= 1'b1;
              dr <= '0;
              edge_r <= hi;
              state <= S_PLACE;
            end else begin
              k <= k + 1'b1;
              state <= S_RD;
            end
          end else begin
            dr <= dr - (WeightW+IdxW+1)'(rc);
            state <= S_PLACE;
            edge_r <= '0;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: state <= S_ADV;
        S_ADV: begin
          dr <= dr + (WeightW+IdxW+1)'(w_rd);
          wk <= w_rd;
          lo <= hi;
          hi <= e_rd;
          state <= S_CHECK;
        end
        S_PLACE: begin
          if (over && ((WeightW+IdxW+1)'(rc) > dr) && dr == '0 && edge_r == hi
              && k >= nd) begin
            out_ch.new_edge <= hi;
            state <= S_EMIT;
            out_ch.valid <= 1'b1;
          end else if (k == '0) begin
            out_ch.new_edge <= '0;
            state <= S_EMIT;
            out_ch.valid <= 1'b1;
          end else if (wk == '0) begin
            out_ch.new_edge <= hi;
            state <= S_EMIT;
            out_ch.valid <= 1'b1;
          end else begin
            state <= S_DIV;
          end
          out_ch.edge_index <= IdxW'(i);
          out_ch.overrun <= over;
          out_ch.last <= 1'b0;
        end
        S_DIV: begin
          if (ddone) begin
            out_ch.new_edge <= hi_ge ? (hi - dquot) : (hi + dquot);
            out_ch.valid <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (out_ch.last) begin
              i <= '0;
              state <= S_COPY;
            end else begin
              i <= i + 1'b1;
              state <= S_EDGE;
            end
          end
        end
        S_COPY: state <= S_COPYW;
        S_COPYW: begin
          if (i + 1'b1 >= nd) begin
            state <= S_IDLE;
          end else begin
            i <= i + 1'b1;
            state <= S_COPY;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/sv/adaptive_grid_rebin_tb.sv
// ----------------------------------------------------------------------------
// adaptive_grid_rebin_tb
// self-checking bench for the grid rebinning block: bin loads and rebin runs
// are driven over the request channel with random gaps, every new edge is
// predicted from a local copy of the stored weights and edges and compared
// field by field as it leaves the result channel under random back-pressure
// ----------------------------------------------------------------------------
module adaptive_grid_rebin_tb;
  import agr_pkg::*;

  typedef struct {
    logic [IdxW-1:0]  idx;
    logic [EdgeW-1:0] edge_v;
    logic             over;
    logic             fin;
  } grid_edge_t;

  typedef struct {
    op_t                op;
    logic [IdxW-1:0]    idx;
    logic [WeightW-1:0] weight;
    logic [EdgeW-1:0]   edge_v;
    logic [WeightW-1:0] step;
    int                 typed_edge;
  } req_row_t;

  localparam int MaxBins = MaxBinsDefault;
  localparam int StallLimit = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IdxW-1:0] cfg_wdata;

  agr_in_if in_ch ();
  agr_out_if out_ch ();

  adaptive_grid_rebin DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  logic [WeightW-1:0] weight_mem[MaxBins];
  logic [EdgeW-1:0]   grid_mem[MaxBins];
  logic [IdxW-1:0]    bins_reg;
  grid_edge_t         pending_edges[$];
  int                 errors;
  int                 quiet_cycles;
  bit                 calm;

  req_row_t directed[] = '{
    '{OP_LOAD, 6'd1,  32'h0,        17'h0,     32'h0, -1},
    '{OP_LOAD, 6'd32, 32'hFFFFFFFF, 17'h1FFFF, 32'h0, -1},
    '{OP_LOAD, 6'd0,  32'h12345678, 17'h1FFFF, 32'h0, -1},
    '{OP_LOAD, 6'd33, 32'hFFFFFFFF, 17'h0,     32'h0, -1},
    '{OP_LOAD, 6'd63, 32'hFFFFFFFF, 17'h1FFFF, 32'hFFFFFFFF, -1},
    '{OP_RUN,  6'd0,  32'h0,        17'h0,     32'h0, 0},
    '{OP_LOAD, 6'd1,  32'h00010000, 17'h02000, 32'h0, -1},
    '{OP_LOAD, 6'd2,  32'h0,        17'h04000, 32'h0, -1},
    '{OP_LOAD, 6'd3,  32'h00020000, 17'h01000, 32'h0, -1},
    '{OP_LOAD, 6'd4,  32'h00010000, 17'h08000, 32'h0, -1},
    '{OP_RUN,  6'd63, 32'hFFFFFFFF, 17'h1FFFF, 32'h00008000, -1},
    '{OP_RUN,  6'd5,  32'h1,        17'h1,     32'hFFFFFFFF, -1},
    '{OP_LOAD, 6'd20, 32'h00030000, 17'h10000, 32'hFFFFFFFF, -1},
    '{OP_RUN,  6'd0,  32'h0,        17'h0,     32'h00010000, -1},
    '{OP_RUN,  6'd0,  32'h0,        17'h0,     32'h00000001, -1},
    '{OP_RUN,  6'd0,  32'h0,        17'h0,     32'h0, 0}
  };

  function automatic logic [EdgeW-1:0] interp_edge(logic [EdgeW-1:0] lo,
      logic [EdgeW-1:0] hi, longint unsigned rem, logic [WeightW-1:0] w);
    longint unsigned mag;
    if (w == 0) return hi;
    if (rem > w) rem = 64'(w);
    if (hi >= lo) begin
      mag = longint'(hi - lo) * rem / w;
      return EdgeW'(longint'(hi) - mag);
    end
    mag = longint'(lo - hi) * rem / w;
    return EdgeW'(longint'(hi) + mag);
  endfunction

  function automatic int bins_used();
    if (bins_reg < 2) return 2;
    if (bins_reg > MaxBins) return MaxBins;
    return int'(bins_reg);
  endfunction

  function automatic void load_bin(logic [IdxW-1:0] idx, logic [WeightW-1:0] w,
      logic [EdgeW-1:0] e);
    if (idx >= 1 && idx <= MaxBins) begin
      weight_mem[idx-1] = w;
      grid_mem[idx-1] = e;
    end
  endfunction

  function automatic void rebin_grid(logic [WeightW-1:0] step, int typed_edge);
    int nd, k;
    longint unsigned rc, dr;
    logic [EdgeW-1:0] lo, hi, e;
    logic [EdgeW-1:0] fresh[MaxBins];
    bit over;
    nd = bins_used();
    rc = 64'(step);
    dr = 0;
    k = 0;
    lo = 0;
    hi = 0;
    over = 0;
    for (int i = 1; i < nd; i++) begin
      while (rc > dr) begin
        if (k >= nd) begin
          over = 1;
          break;
        end
        k++;
        dr += 64'(weight_mem[k-1]);
        lo = hi;
        hi = grid_mem[k-1];
      end
      if (rc > dr) begin
        dr = 0;
        e = hi;
      end else begin
        dr -= rc;
        e = (k == 0) ? '0 : interp_edge(lo, hi, dr, weight_mem[k-1]);
      end
      if (typed_edge >= 0) e = EdgeW'(typed_edge);
      fresh[i-1] = e;
      pending_edges.push_back('{IdxW'(i), e, over, 1'b0});
    end
    fresh[nd-1] = EdgeOne;
    pending_edges.push_back('{IdxW'(nd), EdgeOne, over, 1'b1});
    for (int i = 0; i < nd; i++) grid_mem[i] = fresh[i];
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready = calm || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    grid_edge_t exp_e;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_edges.size() == 0) begin
        $error("unexpected result edge_index=%0d", out_ch.edge_index);
        errors++;
      end else begin
        exp_e = pending_edges.pop_front();
        if (out_ch.edge_index !== exp_e.idx) begin
          $error("edge_index expected %0d got %0d", exp_e.idx, out_ch.edge_index);
          errors++;
        end
        if (out_ch.new_edge !== exp_e.edge_v) begin
          $error("new_edge expected %0h got %0h", exp_e.edge_v, out_ch.new_edge);
          errors++;
        end
        if (out_ch.overrun !== exp_e.over) begin
          $error("overrun expected %0b got %0b", exp_e.over, out_ch.overrun);
          errors++;
        end
        if (out_ch.last !== exp_e.fin) begin
          $error("last expected %0b got %0b", exp_e.fin, out_ch.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_req(op_t op, logic [IdxW-1:0] idx, logic [WeightW-1:0] w,
      logic [EdgeW-1:0] e, logic [WeightW-1:0] step, int typed_edge);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.op = op;
    in_ch.bin_index = idx;
    in_ch.weight = w;
    in_ch.edge_req = e;
    in_ch.step = step;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_LOAD) load_bin(idx, w, e);
    else rebin_grid(step, typed_edge);
  endtask

  // wait until every result is out and the copy back has finished
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 0;
    while (pending_edges.size() != 0 || !in_ch.ready) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_bin_count(logic [IdxW-1:0] v);
    settle();
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    bins_reg = v;
  endtask

  function automatic logic [WeightW-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 255);
      2: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  // mostly a well-formed grid (rising edges ending at one, else random edges), then a step near an equal share
  task automatic reload_and_run(inout int sent);
    int nd;
    longint unsigned total, share;
    logic [WeightW-1:0] w;
    logic [EdgeW-1:0] e;
    bit wild;
    nd = bins_used();
    total = 0;
    wild = ($urandom_range(0, 3) == 0);
    for (int b = 1; b <= nd; b++) begin
      w = rand_weight();
      total += 64'(w);
      if (wild) e = EdgeW'($urandom_range(0, 17'h1FFFF));
      else if (b == nd) e = EdgeOne;
      else e = EdgeW'((b * 65536 + $urandom_range(0, 1500)) / nd);
      send_req(OP_LOAD, IdxW'(b), w, e, $urandom(), -1);
      sent++;
    end
    share = total / nd;
    case ($urandom_range(0, 4))
      0: share = share + $urandom_range(0, 3);
      1: share = total / (nd - 1) + 1;
      2: share = (share > 2) ? share - $urandom_range(0, 2) : share;
      default: ;
    endcase
    if (share > 32'hFFFFFFFF) share = 32'hFFFFFFFF;
    send_req(OP_RUN, IdxW'($urandom()), $urandom(), EdgeW'($urandom()),
             WeightW'(share), -1);
    sent++;
  endtask

  task automatic random_phase(int quota, inout int sent);
    int stop;
    logic [WeightW-1:0] step;
    stop = sent + quota;
    while (sent < stop) begin
      calm = (sent >= 150 && sent < 230);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: reload_and_run(sent);
        6, 7: begin
          case ($urandom_range(0, 3))
            0: step = 0;
            1: step = $urandom();
            2: step = 32'hFFFFFFFF;
            default: step = $urandom_range(1, 32'h0002_0000);
          endcase
          send_req(OP_RUN, IdxW'($urandom()), $urandom(), EdgeW'($urandom()), step, -1);
          sent++;
        end
        8: begin
          send_req(OP_LOAD, IdxW'($urandom_range(0, 63)), $urandom(),
                   EdgeW'($urandom()), $urandom(), -1);
          sent++;
        end
        default: begin
          send_req(OP_LOAD, IdxW'($urandom_range(1, MaxBins)), rand_weight(),
                   EdgeW'($urandom()), $urandom(), -1);
          sent++;
        end
      endcase
    end
    calm = 0;
  endtask

  initial begin
    int sent;
    logic [IdxW-1:0] settings[] = '{6'd2, 6'd32, 6'd0, 6'd63, 6'd1, 6'd7, 6'd25};
    errors = 0;
    quiet_cycles = 0;
    calm = 0;
    sent = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    in_ch.valid = 0;
    in_ch.op = OP_LOAD;
    in_ch.bin_index = '0;
    in_ch.weight = '0;
    in_ch.edge_req = '0;
    in_ch.step = '0;
    out_ch.ready = 0;
    bins_reg = BinCountReset;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // every bin written once so no run ever reads an empty entry
    for (int b = 1; b <= MaxBins; b++)
      send_req(OP_LOAD, IdxW'(b), 32'h0001_0000, EdgeW'(b * 2048), '0, -1);

    foreach (directed[i])
      send_req(directed[i].op, directed[i].idx, directed[i].weight,
               directed[i].edge_v, directed[i].step, directed[i].typed_edge);

    foreach (settings[i]) begin
      write_bin_count(i == settings.size() - 1 ? IdxW'($urandom_range(2, 32)) : settings[i]);
      random_phase(40, sent);
    end

    settle();
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
